// ===== rtl/core/bc1_bc3_block_decoder_macros.svh =====
// assertion helpers included by the prep and row emitter modules
`ifndef BC1_BC3_BLOCK_DECODER_MACROS_SVH
`define BC1_BC3_BLOCK_DECODER_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define BC13_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define BC13_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bc13_pkg.sv =====
`timescale 1ns / 1ps

package bc13_pkg;

    // reciprocals for truncating division by 3, 5 and 7
    localparam logic [9:0]  RECIP3 = 10'd683;
    localparam logic [11:0] RECIP5 = 12'd3277;
    localparam logic [11:0] RECIP7 = 12'd2341;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    localparam logic [1:0] LAST_ROW = 2'd3;

    // decoded endpoints and interpolation sums, one block
    typedef struct packed {
        logic              four;
        logic              bc3;
        logic              amode8;
        logic [2:0][7:0]   e0;
        logic [2:0][7:0]   e1;
        logic [2:0][9:0]   sum_a;
        logic [2:0][9:0]   sum_b;
        logic [7:0]        a0;
        logic [7:0]        a1;
        logic [5:0][10:0]  anum;
        logic [31:0]       cidx;
        logic [47:0]       aidx;
    } prep_t;

    // finished palettes plus the texel indices, one block
    typedef struct packed {
        logic [3:0][23:0]  pal;
        logic [7:0][7:0]   apal;
        logic [31:0]       cidx;
        logic [47:0]       aidx;
    } pal_blk_t;

    // widen a 5-bit channel by bit replication
    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    // widen a 6-bit channel by bit replication
    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    // floor(x / 3) for x below 768
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'(RECIP3);
        return p[18:11];
    endfunction

    // floor(x / 5) for x up to 1275
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'(RECIP5);
        return p[21:14];
    endfunction

    // floor(x / 7) for x up to 1785
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'(RECIP7);
        return p[21:14];
    endfunction

endpackage

// ===== rtl/core/bc1_bc3_block_decoder.sv =====
`timescale 1ns / 1ps

// BC1/BC3 block decoder: takes one compressed 4x4 block per item on the s_ side
// (tdata bits 63:0 alpha half, 127:64 color half) and returns four row items on
// the m_ side, top row first, each with four RGBA8 texels, the row number in
// tuser and tlast on the fourth row. A block passes a prep stage, a palette
// stage and a row emitter, held in turn in the prep, palette, block holder and
// output registers. The row emitter sends one row per cycle while m_tready is
// high and takes the next block as the last row of the old one is loaded, so
// back to back blocks keep the output busy every cycle. Register 0 (block_format,
// byte address 0) picks BC1 when 0 and BC3 when 1; write it only while idle.

module bc1_bc3_block_decoder (
    input  logic         aclk,
    input  logic         aresetn,
    // block input
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // alpha_block, color_block
    // row output
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // pixel_zero, pixel_one, pixel_two, pixel_three
    output logic [1:0]   m_tuser,   // row_index
    output logic         m_tlast,   // last_row
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import bc13_pkg::*;

    logic     fmt_reg;
    logic     prep_valid;
    logic     prep_ready;
    prep_t    prep_data;
    logic     pal_valid;
    logic     pal_ready;
    pal_blk_t pal_data;

    // configuration register
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {31'd0, fmt_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            fmt_reg <= pwdata[0];
        end
    end

    // endpoint and numerator stage
    bc13_prep u_prep (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .bc3_mode    (fmt_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .alpha_block (s_tdata[63:0]),
        .color_block (s_tdata[127:64]),
        .out_valid   (prep_valid),
        .out_ready   (prep_ready),
        .out_data    (prep_data)
    );

    // palette stage
    bc13_palette u_palette (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (pal_valid),
        .out_ready (pal_ready),
        .out_data  (pal_data)
    );

    // row emitter with output register
    bc13_row_emit u_row_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pal_valid),
        .in_ready (pal_ready),
        .in_data  (pal_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/core/bc13_prep.sv =====
`timescale 1ns / 1ps
`include "bc1_bc3_block_decoder_macros.svh"

module bc13_prep (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            bc3_mode,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [63:0]     alpha_block,
    input  logic [63:0]     color_block,
    output logic            out_valid,
    input  logic            out_ready,
    output bc13_pkg::prep_t out_data
);
    import bc13_pkg::*;

    logic  vld_reg;
    prep_t data_reg;
    prep_t data_next;

    // endpoint widening, mode choice and palette numerators
    always_comb begin
        logic [15:0] c0;
        logic [15:0] c1;
        logic [10:0] wa;
        logic [10:0] wb;
        c0 = color_block[15:0];
        c1 = color_block[31:16];
        data_next.bc3  = bc3_mode;
        data_next.four = bc3_mode || (c0 > c1);
        data_next.e0[0] = widen5(c0[15:11]);
        data_next.e0[1] = widen6(c0[10:5]);
        data_next.e0[2] = widen5(c0[4:0]);
        data_next.e1[0] = widen5(c1[15:11]);
        data_next.e1[1] = widen6(c1[10:5]);
        data_next.e1[2] = widen5(c1[4:0]);
        for (int ch = 0; ch < 3; ch++) begin
            if (data_next.four) begin
                data_next.sum_a[ch] = {1'b0, data_next.e0[ch], 1'b0} + 10'(data_next.e1[ch]);
            end else begin
                data_next.sum_a[ch] = 10'(data_next.e0[ch]) + 10'(data_next.e1[ch]);
            end
            data_next.sum_b[ch] = 10'(data_next.e0[ch]) + {1'b0, data_next.e1[ch], 1'b0};
        end
        data_next.a0     = alpha_block[7:0];
        data_next.a1     = alpha_block[15:8];
        data_next.amode8 = alpha_block[7:0] > alpha_block[15:8];
        wa = 11'(alpha_block[7:0]);
        wb = 11'(alpha_block[15:8]);
        for (int k = 1; k <= 6; k++) begin
            if (data_next.amode8) begin
                data_next.anum[k-1] = 11'(7 - k) * wa + 11'(k) * wb;
            end else if (k <= 4) begin
                data_next.anum[k-1] = 11'(5 - k) * wa + 11'(k) * wb;
            end else begin
                data_next.anum[k-1] = '0;
            end
        end
        data_next.cidx = color_block[63:32];
        data_next.aidx = alpha_block[63:16];
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/core/bc13_palette.sv =====
`timescale 1ns / 1ps

module bc13_palette (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  bc13_pkg::prep_t    in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bc13_pkg::pal_blk_t out_data
);
    import bc13_pkg::*;

    logic     vld_reg;
    pal_blk_t data_reg;
    pal_blk_t data_next;

    // color and alpha palettes by reciprocal multiplication, with a halving shift for the three-color midpoint
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            data_next.pal[0][8*ch +: 8] = in_data.e0[ch];
            data_next.pal[1][8*ch +: 8] = in_data.e1[ch];
            if (in_data.four) begin
                data_next.pal[2][8*ch +: 8] = div3(in_data.sum_a[ch]);
                data_next.pal[3][8*ch +: 8] = div3(in_data.sum_b[ch]);
            end else begin
                data_next.pal[2][8*ch +: 8] = in_data.sum_a[ch][8:1];
                data_next.pal[3][8*ch +: 8] = 8'h00;
            end
        end
        if (!in_data.bc3) begin
            data_next.apal = {8{ALPHA_OPAQUE}};
        end else begin
            data_next.apal[0] = in_data.a0;
            data_next.apal[1] = in_data.a1;
            for (int k = 1; k <= 6; k++) begin
                if (in_data.amode8) begin
                    data_next.apal[k+1] = div7(in_data.anum[k-1]);
                end else begin
                    data_next.apal[k+1] = div5(in_data.anum[k-1]);
                end
            end
            if (!in_data.amode8) begin
                data_next.apal[6] = ALPHA_CLEAR;
                data_next.apal[7] = ALPHA_OPAQUE;
            end
        end
        data_next.cidx = in_data.cidx;
        data_next.aidx = in_data.aidx;
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/core/bc13_row_emit.sv =====
`timescale 1ns / 1ps
`include "bc1_bc3_block_decoder_macros.svh"

module bc13_row_emit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  bc13_pkg::pal_blk_t in_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [127:0]       m_tdata,   // pixel_zero, pixel_one, pixel_two, pixel_three
    output logic [1:0]         m_tuser,   // row_index
    output logic               m_tlast
);
    import bc13_pkg::*;

    logic             blk_vld_reg;
    pal_blk_t         blk_reg;
    logic [1:0]       row_cnt_reg;
    logic             out_vld_reg;
    logic [1:0]       out_row_reg;
    logic             out_last_reg;
    logic [3:0][31:0] out_pix_reg;
    logic [3:0][31:0] out_pix_next;
    logic             out_load;

    // select the texels of the current row from the palettes
    always_comb begin
        logic [3:0] t;
        logic [4:0] coff;
        logic [5:0] aoff;
        logic [1:0] ci;
        logic [2:0] ai;
        for (int col = 0; col < 4; col++) begin
            t    = {row_cnt_reg, 2'(col)};
            coff = {t, 1'b0};
            aoff = {1'b0, t, 1'b0} + {2'b00, t};
            ci   = blk_reg.cidx[coff +: 2];
            ai   = blk_reg.aidx[aoff +: 3];
            out_pix_next[col] = {blk_reg.apal[ai], blk_reg.pal[ci]};
        end
    end

    assign out_load = blk_vld_reg && (!out_vld_reg || m_tready);
    assign in_ready = !blk_vld_reg || (out_load && (row_cnt_reg == LAST_ROW));

    // block holder, row counter and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_vld_reg <= 1'b0;
            row_cnt_reg <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (out_load) begin
                out_vld_reg <= 1'b1;
                row_cnt_reg <= row_cnt_reg + 2'd1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
            // a new block takes over as the last row of the old one leaves
            if (in_valid && in_ready) begin
                blk_vld_reg <= 1'b1;
            end else if (out_load && (row_cnt_reg == LAST_ROW)) begin
                blk_vld_reg <= 1'b0;
            end
        end
        if (out_load) begin
            out_pix_reg  <= out_pix_next;
            out_row_reg  <= row_cnt_reg;
            out_last_reg <= (row_cnt_reg == LAST_ROW);
        end
        if (in_valid && in_ready) begin
            blk_reg <= in_data;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tuser  = out_row_reg;
    assign m_tlast  = out_last_reg;

    // rows of one block leave back to back and in order
    `BC13_ASSERT_NEXT(a_row_step, out_vld_reg && m_tready && !out_last_reg, out_vld_reg && (out_row_reg == $past(out_row_reg) + 2'd1), "row sequence broken")
    // a block in flight is never dropped mid-run
    `BC13_ASSERT_IMPL(a_cnt_blk, row_cnt_reg != 2'd0, blk_vld_reg, "row counter without block")
    // a new block only replaces one whose last row is leaving
    `BC13_ASSERT_IMPL(a_no_overwrite, in_valid && in_ready && blk_vld_reg, out_load && (row_cnt_reg == LAST_ROW), "block overwritten early")
    // last marker follows the row number
    `BC13_ASSERT_IMPL(a_last_row, out_vld_reg, out_last_reg == (out_row_reg == LAST_ROW), "last marker mismatch")

endmodule

// ===== sim/bc1_bc3_block_decoder_test.sv =====
`timescale 1ns / 1ps

module bc1_bc3_block_decoder_test;

    import bc13_pkg::*;

    localparam logic [2:0] REG_FORMAT_ADDR = 3'd0;
    localparam logic [2:0] REG_SPARE_ADDR  = 3'd4;
    localparam int         SETTLE_CYCLES   = 8;
    localparam int         CYCLE_LIMIT     = 400000;

    typedef enum logic { FMT_BC1 = 1'b0, FMT_BC3 = 1'b1 } fmt_t;
    typedef enum logic [1:0] { RX_STEADY, RX_COIN, RX_PERIODIC, RX_SPARSE } rx_mode_t;

    // one decoded texel row as it should leave the block
    typedef struct packed {
        logic [1:0]       row;
        logic [3:0][31:0] px;
        logic             last;
    } row_exp_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;     // alpha_block, color_block
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;          // pixel_zero, pixel_one, pixel_two, pixel_three
    logic [1:0]   m_tuser;          // row_index
    logic         m_tlast;          // last_row
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    fmt_t         fmt_copy = FMT_BC1;
    logic [127:0] blk_pending[$];
    row_exp_t     row_expect[$];
    logic         blk_taken = 1'b0;
    int           err_count = 0;
    int           blk_count = 0;
    int           row_count = 0;
    int           bc1_blocks = 0;
    int           bc3_blocks = 0;
    int           cyc_count = 0;

    bc1_bc3_block_decoder u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // decode one block into its four expected rows
    function automatic void decode_block(input logic [63:0] ablk, input logic [63:0] cblk);
        logic [15:0]      c0;
        logic [15:0]      c1;
        logic [2:0][7:0]  e0;
        logic [2:0][7:0]  e1;
        logic [3:0][23:0] pal;
        logic [7:0]       apal[8];
        logic             four;
        logic [7:0]       a0;
        logic [7:0]       a1;
        logic [7:0]       rowbits;
        logic [1:0]       ci;
        logic [2:0]       ai;
        int unsigned      x;
        int unsigned      y;
        row_exp_t         r;

        c0 = cblk[15:0];
        c1 = cblk[31:16];
        e0[0] = {c0[15:11], c0[15:13]};
        e0[1] = {c0[10:5], c0[10:9]};
        e0[2] = {c0[4:0], c0[4:2]};
        e1[0] = {c1[15:11], c1[15:13]};
        e1[1] = {c1[10:5], c1[10:9]};
        e1[2] = {c1[4:0], c1[4:2]};
        four = (fmt_copy == FMT_BC3) || (c0 > c1);

        // color palette, per channel
        for (int ch = 0; ch < 3; ch++) begin
            x = e0[ch];
            y = e1[ch];
            pal[0][8*ch +: 8] = e0[ch];
            pal[1][8*ch +: 8] = e1[ch];
            if (four) begin
                pal[2][8*ch +: 8] = 8'((2 * x + y) / 3);
                pal[3][8*ch +: 8] = 8'((x + 2 * y) / 3);
            end else begin
                pal[2][8*ch +: 8] = 8'((x + y) / 2);
                pal[3][8*ch +: 8] = 8'd0;
            end
        end

        // alpha palette, opaque everywhere in bc1
        if (fmt_copy == FMT_BC3) begin
            a0 = ablk[7:0];
            a1 = ablk[15:8];
            apal[0] = a0;
            apal[1] = a1;
            if (a0 > a1) begin
                for (int k = 1; k <= 6; k++)
                    apal[k + 1] = 8'(((7 - k) * int'(a0) + k * int'(a1)) / 7);
            end else begin
                for (int k = 1; k <= 4; k++)
                    apal[k + 1] = 8'(((5 - k) * int'(a0) + k * int'(a1)) / 5);
                apal[6] = ALPHA_CLEAR;
                apal[7] = ALPHA_OPAQUE;
            end
        end else begin
            for (int k = 0; k < 8; k++)
                apal[k] = ALPHA_OPAQUE;
        end

        for (int rw = 0; rw < 4; rw++) begin
            rowbits = cblk[32 + 8 * rw +: 8];
            r.row = 2'(rw);
            for (int col = 0; col < 4; col++) begin
                ci = rowbits[2 * col +: 2];
                ai = ablk[16 + 3 * (rw * 4 + col) +: 3];
                r.px[col] = {apal[ai], pal[ci]};
            end
            r.last = (2'(rw) == LAST_ROW);
            row_expect.insert(row_expect.size(), r);
        end
    endfunction

    // random block, sometimes with equal endpoints, extreme alphas or extreme colors
    function automatic logic [127:0] rand_block();
        logic [63:0] ablk;
        logic [63:0] cblk;
        ablk = {$urandom, $urandom};
        cblk = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: cblk[31:16] = cblk[15:0];
            1: ablk[15:8] = ablk[7:0];
            2: ablk[15:0] = {8'h00, 8'hFF};
            3: ablk[15:0] = {8'hFF, 8'h00};
            4: cblk[31:0] = {16'h0000, 16'hFFFF};
            default: ;
        endcase
        return {cblk, ablk};
    endfunction

    function automatic void add_block(input logic [63:0] ablk, input logic [63:0] cblk);
        blk_pending.insert(blk_pending.size(), {cblk, ablk});
    endfunction

    task automatic report_diff(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
        err_count++;
    endtask

    // register write: setup cycle then access cycle
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == REG_FORMAT_ADDR)
            fmt_copy = fmt_t'(val[0]);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait until every queued item is in and every row is out
    task automatic wait_idle();
        while (blk_pending.size() != 0 || s_tvalid || row_expect.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // block driver: bursts of random length with random gaps
    always @(negedge aclk) begin : blk_driver
        int           burst_left;
        int           gap_left;
        logic         nxt_valid;
        logic [127:0] nxt_data;
        nxt_valid = 1'b0;
        nxt_data  = s_tdata;
        if (!aresetn) begin
            burst_left = 0;
            gap_left   = 0;
            s_tvalid  <= 1'b0;
        end else if (s_tvalid && !blk_taken) begin
            // hold the item until it is taken
        end else begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (blk_pending.size() > 0) begin
                nxt_data  = blk_pending.pop_front();
                nxt_valid = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        3:       gap_left = $urandom_range(4, 12);
                        default: gap_left = $urandom_range(1, 3);
                    endcase
                end
            end
            s_tvalid <= nxt_valid;
            s_tdata  <= nxt_data;
        end
    end

    // row receiver: stalls in one of four patterns, chosen anew after each run
    always @(negedge aclk) begin : row_receiver
        int       run_left;
        rx_mode_t mode;
        logic     rdy;
        if (!aresetn) begin
            run_left = 0;
            mode     = RX_STEADY;
            m_tready <= 1'b0;
        end else begin
            if (run_left == 0) begin
                mode     = rx_mode_t'($urandom_range(0, 3));
                run_left = $urandom_range(20, 120);
            end
            run_left--;
            case (mode)
                RX_STEADY:   rdy = 1'b1;
                RX_COIN:     rdy = 1'($urandom_range(0, 1));
                RX_PERIODIC: rdy = (cyc_count % 3) != 0;
                default:     rdy = ($urandom_range(0, 7) == 0);
            endcase
            m_tready <= rdy;
        end
    end

    // input acceptance and row checking
    always @(posedge aclk) begin : row_monitor
        row_exp_t want;
        if (!aresetn) begin
            blk_taken <= 1'b0;
        end else begin
            blk_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                decode_block(s_tdata[63:0], s_tdata[127:64]);
                blk_count++;
                if (fmt_copy == FMT_BC3)
                    bc3_blocks++;
                else
                    bc1_blocks++;
            end
            if (m_tvalid && m_tready) begin
                row_count++;
                if (row_expect.size() == 0) begin
                    $display("%0t ns: unexpected row, expected none, actual row %0d",
                             $time, m_tuser);
                    err_count++;
                end else begin
                    want = row_expect.pop_front();
                    if (m_tuser !== want.row)
                        report_diff("row_index", 32'(want.row), 32'(m_tuser));
                    for (int col = 0; col < 4; col++)
                        if (m_tdata[32 * col +: 32] !== want.px[col])
                            report_diff($sformatf("row %0d texel %0d", want.row, col),
                                        want.px[col], m_tdata[32 * col +: 32]);
                    if (m_tlast !== want.last)
                        report_diff("last_row", 32'(want.last), 32'(m_tlast));
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin : watchdog
        cyc_count++;
        if (cyc_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d rows still due", cyc_count,
                     row_expect.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : stimulus
        logic [47:0] aidx_ramp;

        // alpha indices 0..7 twice over the sixteen texels
        for (int t = 0; t < 16; t++)
            aidx_ramp[3 * t +: 3] = 3'(t % 8);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // bc1, upper bits of the write must be dropped
        reg_write(REG_FORMAT_ADDR, 32'hFFFF_FFFE);
        add_block(64'h0, {32'hE4E4_E4E4, 16'h0000, 16'hFFFF});
        add_block(64'h0, {32'hE4E4_E4E4, 16'hFFFF, 16'h0000});
        add_block({$urandom, $urandom}, {32'h1B1B_1B1B, 16'h1234, 16'h1234});
        add_block(64'h0, 64'h0);
        add_block({64{1'b1}}, {64{1'b1}});
        add_block(64'h0, {$urandom, 16'h07E0, 16'hF800});
        add_block(64'h0, {$urandom, 16'hF800, 16'h001F});
        add_block(64'h0, {32'hFFFF_FFFF, 16'h8000, 16'h8001});
        add_block(64'h0, {32'hFFFF_FFFF, 16'h8001, 16'h8000});
        for (int i = 0; i < 150; i++)
            blk_pending.insert(blk_pending.size(), rand_block());
        wait_idle();

        // bc3, plus a write to an unmapped register that must be ignored
        reg_write(REG_FORMAT_ADDR, 32'h0000_0001);
        reg_write(REG_SPARE_ADDR, 32'h0000_0000);
        add_block({aidx_ramp, 8'h00, 8'hFF}, {32'hE4E4_E4E4, 16'hFFFF, 16'h0000});
        add_block({aidx_ramp, 8'hFF, 8'h00}, {32'hE4E4_E4E4, 16'h0000, 16'hFFFF});
        add_block({aidx_ramp, 8'h80, 8'h80}, {32'h1B1B_1B1B, 16'h4321, 16'h4321});
        add_block({aidx_ramp, 8'h80, 8'h81}, {$urandom, 16'h07E0, 16'hF800});
        add_block({aidx_ramp, 8'h81, 8'h80}, {$urandom, 16'hF800, 16'h07E0});
        add_block({~aidx_ramp, 8'h10, 8'hF0}, {32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF});
        add_block({aidx_ramp, 8'hF0, 8'h10}, {32'h0000_0000, 16'h0001, 16'h0000});
        add_block({64{1'b1}}, {64{1'b1}});
        add_block(64'h0, 64'h0);
        for (int i = 0; i < 200; i++)
            blk_pending.insert(blk_pending.size(), rand_block());
        wait_idle();

        // back to bc1, then bc3 again
        reg_write(REG_FORMAT_ADDR, 32'hFFFF_FFFE);
        for (int i = 0; i < 75; i++)
            blk_pending.insert(blk_pending.size(), rand_block());
        wait_idle();
        reg_write(REG_FORMAT_ADDR, 32'h0000_0003);
        for (int i = 0; i < 75; i++)
            blk_pending.insert(blk_pending.size(), rand_block());
        wait_idle();

        $display("decoded %0d blocks (%0d bc1, %0d bc3) over four format settings",
                 blk_count, bc1_blocks, bc3_blocks);
        $display("checked %0d rows with random gaps and receiver stalls", row_count);
        if (err_count == 0 && row_expect.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d rows never arrived", err_count, row_expect.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/bc13_pkg.sv
rtl/core/bc13_prep.sv
rtl/core/bc13_palette.sv
rtl/core/bc13_row_emit.sv
rtl/core/bc1_bc3_block_decoder.sv
sim/bc1_bc3_block_decoder_test.sv
